[src/pid_pkg.sv]
// Shared types, constants and helpers for the palette image decoder.
// Used by palette_image_decoder_core and its testbench; no dependencies.
package pid_pkg;

  // Palette store geometry
  localparam int unsigned PAL_DEPTH   = 256;
  localparam int unsigned COLOR_W     = 32;
  localparam int unsigned DIM_W       = 9;
  localparam int unsigned PIXCNT_W    = 17;

  // Result kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Supported file version
  localparam logic [7:0] VERSION_0 = 8'h00;

  // Parser phases
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WIDTH,
    PH_HEIGHT,
    PH_COUNT,
    PH_PALETTE,
    PH_PIXELS,
    PH_DONE
  } phase_e;

  // Header size byte: zero encodes 256
  function automatic logic [DIM_W-1:0] size_of_byte(input logic [7:0] b);
    logic [DIM_W-1:0] r;
    if (b == 8'd0) r = DIM_W'(256);
    else           r = {1'b0, b};
    return r;
  endfunction

  // floor(c*a/255), exact for 16-bit products via (x + (x>>8) + 1) >> 8
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] p;
    logic [16:0] s;
    p = c * a;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

[src/pid_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// Depends on nothing; data holds while no read is issued.
module pid_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/palette_image_decoder_core.sv]
// Top level of the palette image decoder: header parser, palette store and
// result pipeline. Depends on pid_pkg and pid_ram.
//
// The core takes one file byte per clock cycle without gaps; the input stalls
// only while stage 1 and the output register both hold a result and the
// output is stalled. A byte with file_start_i high is the
// version byte and restarts parsing; version 0 is followed by width, height
// and palette count bytes (zero means 256), then four bytes (R, G, B, A) per
// palette entry, then one index byte per pixel. Palette entries are stored
// premultiplied as packed ARGB in a 256 x 32 synchronous RAM, written on the
// alpha byte. Each pixel index reads the RAM once; its result passes through
// stage 1 (RAM read) and then the output register. A nonzero version gives a
// single error result and the rest of that file is dropped; bytes after the
// final pixel are dropped too. Palette entries are not cleared at reset.
module palette_image_decoder_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input byte channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       file_start_i,
  // Result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic [pid_pkg::COLOR_W-1:0] color_o,
  output logic                       last_pixel_o,
  output logic [pid_pkg::DIM_W-1:0]  image_width_o,
  output logic [pid_pkg::DIM_W-1:0]  image_height_o
);

  import pid_pkg::*;

  localparam int unsigned AddrW = $clog2(PAL_DEPTH);

  // Side data travelling alongside the RAM read
  typedef struct packed {
    logic             kind;
    logic             in_range;
    logic             last;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } res_info_t;

  // Parser state
  phase_e              phase_q, phase_d;
  logic [DIM_W-1:0]    width_q, width_d;
  logic [DIM_W-1:0]    height_q, height_d;
  logic [DIM_W-1:0]    count_q, count_d;
  logic [DIM_W-1:0]    entry_q, entry_d;
  logic [1:0]          comp_q, comp_d;
  logic [23:0]         held_q, held_d;
  logic [PIXCNT_W-1:0] pixels_q, pixels_d;

  // Per-transaction results of the parser
  logic                accept;
  logic                res_valid;
  res_info_t           res_info;
  logic                ram_we;
  logic [COLOR_W-1:0]  ram_wdata;
  logic                ram_re;
  logic [COLOR_W-1:0]  ram_rdata;
  logic [DIM_W:0]      entry_inc;
  logic [2*DIM_W-1:0]  area;

  // Pipeline registers
  logic                s1_valid_q, s1_valid_d;
  res_info_t           s1_info_q;
  logic                s1_adv;
  logic                out_valid_q, out_valid_d;
  logic                out_kind_q;
  logic [COLOR_W-1:0]  out_color_q;
  logic                out_last_q;
  logic [DIM_W-1:0]    out_width_q;
  logic [DIM_W-1:0]    out_height_q;

  // Handshake: stage 1 drains into the output register
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign entry_inc = {1'b0, entry_q} + (DIM_W+1)'(1);
  assign area      = width_q * height_q;

  // Premultiplied ARGB of the entry completed by the alpha byte
  assign ram_wdata = {data_byte_i,
                      premul(held_q[23:16], data_byte_i),
                      premul(held_q[15:8], data_byte_i),
                      premul(held_q[7:0], data_byte_i)};

  // Parser next state and result generation
  always_comb begin
    phase_d   = phase_q;
    width_d   = width_q;
    height_d  = height_q;
    count_d   = count_q;
    entry_d   = entry_q;
    comp_d    = comp_q;
    held_d    = held_q;
    pixels_d  = pixels_q;
    res_valid = 1'b0;
    res_info  = '{kind: KIND_PIXEL, in_range: 1'b0, last: 1'b0,
                  width: '0, height: '0};
    ram_we    = 1'b0;
    ram_re    = 1'b0;

    if (accept) begin
      if (file_start_i) begin
        entry_d  = '0;
        comp_d   = '0;
        held_d   = '0;
        pixels_d = '0;
        if (data_byte_i == VERSION_0) begin
          phase_d = PH_WIDTH;
        end else begin
          phase_d        = PH_DONE;
          res_valid      = 1'b1;
          res_info.kind  = KIND_ERROR;
        end
      end else begin
        unique case (phase_q)
          PH_WIDTH: begin
            width_d = size_of_byte(data_byte_i);
            phase_d = PH_HEIGHT;
          end
          PH_HEIGHT: begin
            height_d = size_of_byte(data_byte_i);
            phase_d  = PH_COUNT;
          end
          PH_COUNT: begin
            count_d = size_of_byte(data_byte_i);
            entry_d = '0;
            comp_d  = '0;
            phase_d = PH_PALETTE;
          end
          PH_PALETTE: begin
            if (comp_q != 2'd3) begin
              // collect R, G, B
              case (comp_q)
                2'd0:    held_d[23:16] = data_byte_i;
                2'd1:    held_d[15:8]  = data_byte_i;
                default: held_d[7:0]   = data_byte_i;
              endcase
              comp_d = comp_q + 2'd1;
            end else begin
              // alpha byte: store entry
              ram_we  = 1'b1;
              comp_d  = '0;
              entry_d = entry_inc[DIM_W-1:0];
              if (entry_inc[DIM_W-1:0] >= count_q) begin
                pixels_d = area[PIXCNT_W-1:0];
                phase_d  = PH_PIXELS;
              end
            end
          end
          PH_PIXELS: begin
            ram_re            = 1'b1;
            pixels_d          = pixels_q - PIXCNT_W'(1);
            res_valid         = 1'b1;
            res_info.in_range = {1'b0, data_byte_i} < count_q;
            res_info.last     = (pixels_d == '0);
            res_info.width    = width_q;
            res_info.height   = height_q;
            if (pixels_d == '0) begin
              phase_d = PH_DONE;
            end
          end
          PH_IDLE, PH_DONE: begin
            phase_d = phase_q;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  // Parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      width_q  <= DIM_W'(256);
      height_q <= DIM_W'(256);
      count_q  <= DIM_W'(256);
      entry_q  <= '0;
      comp_q   <= '0;
      held_q   <= '0;
      pixels_q <= '0;
    end else begin
      phase_q  <= phase_d;
      width_q  <= width_d;
      height_q <= height_d;
      count_q  <= count_d;
      entry_q  <= entry_d;
      comp_q   <= comp_d;
      held_q   <= held_d;
      pixels_q <= pixels_d;
    end
  end

  // Palette store
  pid_ram #(
    .Width (COLOR_W),
    .Depth (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_q[AddrW-1:0]),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (data_byte_i[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Stage 1: waits for RAM read data
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept)      s1_valid_d = res_valid;
    else if (s1_adv) s1_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_info_q <= res_info;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv)            out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_kind_q   <= s1_info_q.kind;
      out_color_q  <= (s1_info_q.kind == KIND_PIXEL && s1_info_q.in_range) ?
                      ram_rdata : '0;
      out_last_q   <= s1_info_q.last;
      out_width_q  <= s1_info_q.width;
      out_height_q <= s1_info_q.height;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = out_kind_q;
  assign color_o        = out_color_q;
  assign last_pixel_o   = out_last_q;
  assign image_width_o  = out_width_q;
  assign image_height_o = out_height_q;

  // Checks
  a_err_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_kind_q == KIND_ERROR |->
      out_color_q == '0 && !out_last_q && out_width_q == '0 && out_height_q == '0)
    else $error("error result carries nonzero fields");

  a_write_only_on_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> phase_q == PH_PALETTE && comp_q == 2'd3 && !file_start_i)
    else $error("palette write outside alpha byte");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_info_q))
    else $error("stage 1 lost or changed a pending transaction");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with free pipeline space");

  a_last_ends_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid && res_info.last |=> phase_q == PH_DONE)
    else $error("parser did not finish after last pixel");

endmodule

[dv/tb_top.sv]
// Self-checking testbench for palette_image_decoder_core: streams image files
// into the byte channel and checks every result against a local predictor.
// Depends on pid_pkg and the core RTL only.
module tb_top;
  import pid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned END_CYCLES  = 20;
  localparam int unsigned RAND_BYTES  = 1180;
  localparam logic [1:0]  ALPHA_SLOT  = 2'd3;

  // One decoder result, field for field as on the output ports
  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } decoded_t;

  // One byte waiting to be sent; drain holds it back until all results are in
  typedef struct {
    logic [7:0] data;
    logic       start;
    bit         drain;
  } file_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [7:0]          data_byte_i = 8'd0;
  logic                file_start_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic                kind_o;
  logic [COLOR_W-1:0]  color_o;
  logic                last_pixel_o;
  logic [DIM_W-1:0]    image_width_o;
  logic [DIM_W-1:0]    image_height_o;

  file_byte_t  bytes_to_send[$];
  decoded_t    results_due[$];
  int unsigned queued_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned rx_count = 0;
  int unsigned rx_hold = 0;
  int unsigned tx_gap = 0;
  int unsigned rx_gap = 0;
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;

  // Predictor state
  phase_e             phase_q = PH_IDLE;
  logic [DIM_W-1:0]   width_q = 9'd256;
  logic [DIM_W-1:0]   height_q = 9'd256;
  logic [DIM_W-1:0]   count_q = 9'd256;
  logic [DIM_W-1:0]   entry_q = '0;
  logic [1:0]         comp_q = '0;
  logic [23:0]        rgb_q = '0;
  logic [PIXCNT_W-1:0] left_q = '0;
  logic [COLOR_W-1:0] palette_q [PAL_DEPTH];

  palette_image_decoder_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .file_start_i   (file_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .color_o        (color_o),
    .last_pixel_o   (last_pixel_o),
    .image_width_o  (image_width_o),
    .image_height_o (image_height_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // Header size byte, zero standing for 256
  function automatic logic [DIM_W-1:0] dim_of(input logic [7:0] b);
    return (b == 8'd0) ? 9'd256 : {1'b0, b};
  endfunction

  // floor(c * a / 255)
  function automatic logic [7:0] scale_by_alpha(input logic [7:0] c, input logic [7:0] a);
    logic [15:0] prod;
    prod = {8'd0, c} * {8'd0, a};
    return 8'(prod / 16'd255);
  endfunction

  // Idle cycles before the next transaction; none while in a burst stretch
  function automatic int unsigned draw_gap(input bit burst);
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  // Advance the predictor by one accepted byte, queueing any result
  task automatic decode_byte(input logic [7:0] b, input logic start);
    decoded_t         res;
    logic [COLOR_W-1:0] col;
    if (start) begin
      entry_q = '0;
      comp_q  = '0;
      rgb_q   = '0;
      left_q  = '0;
      if (b == VERSION_0) begin
        phase_q = PH_WIDTH;
      end else begin
        phase_q = PH_DONE;
        res = '{KIND_ERROR, '0, 1'b0, '0, '0};
        results_due.push_back(res);
      end
    end else begin
      case (phase_q)
        PH_WIDTH: begin
          width_q = dim_of(b);
          phase_q = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_q = dim_of(b);
          phase_q  = PH_COUNT;
        end
        PH_COUNT: begin
          count_q = dim_of(b);
          entry_q = '0;
          comp_q  = '0;
          phase_q = PH_PALETTE;
        end
        PH_PALETTE: begin
          if (comp_q != ALPHA_SLOT) begin
            case (comp_q)
              2'd0:    rgb_q[23:16] = b;
              2'd1:    rgb_q[15:8]  = b;
              default: rgb_q[7:0]   = b;
            endcase
            comp_q = comp_q + 2'd1;
          end else begin
            col = {b, scale_by_alpha(rgb_q[23:16], b), scale_by_alpha(rgb_q[15:8], b),
                   scale_by_alpha(rgb_q[7:0], b)};
            palette_q[entry_q[7:0]] = col;
            comp_q  = '0;
            entry_q = entry_q + 9'd1;
            if (entry_q >= count_q) begin
              left_q  = {8'd0, width_q} * {8'd0, height_q};
              phase_q = PH_PIXELS;
            end
          end
        end
        PH_PIXELS: begin
          col    = ({1'b0, b} < count_q) ? palette_q[b] : '0;
          left_q = left_q - 1'b1;
          res    = '{KIND_PIXEL, col, left_q == '0, width_q, height_q};
          if (left_q == '0) phase_q = PH_DONE;
          results_due.push_back(res);
        end
        default: ;
      endcase
    end
  endtask

  task automatic add_byte(input logic [7:0] data, input logic start, input bit drain);
    file_byte_t item;
    item = '{data, start, drain};
    bytes_to_send.push_back(item);
    queued_cnt++;
  endtask

  // Queue one file; cut > 0 truncates it, tail adds bytes after the last pixel
  task automatic add_file(input logic [7:0] ver, input logic [7:0] wb, input logic [7:0] hb,
                          input logic [7:0] cb, input int cut, input int tail,
                          input bit drain);
    logic [7:0] fb[$];
    int         n_pal;
    int         n_pix;
    int         lim;
    fb.push_back(ver);
    if (ver == VERSION_0) begin
      fb.push_back(wb);
      fb.push_back(hb);
      fb.push_back(cb);
      n_pal = int'(dim_of(cb));
      n_pix = int'(dim_of(wb)) * int'(dim_of(hb));
      for (int i = 0; i < n_pal; i++) begin
        repeat (3) fb.push_back(8'($urandom));
        case ($urandom_range(0, 3))
          0:       fb.push_back(8'h00);
          1:       fb.push_back(8'hFF);
          default: fb.push_back(8'($urandom));
        endcase
      end
      for (int i = 0; i < n_pix; i++) begin
        if ($urandom_range(0, 6) != 0) fb.push_back(8'($urandom_range(0, n_pal - 1)));
        else                           fb.push_back(8'($urandom));
      end
    end
    for (int i = 0; i < tail; i++) fb.push_back(8'($urandom));
    lim = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < lim; i++) add_byte(fb[i], i == 0, drain && i == 0);
  endtask

  // Driver: offers queued bytes, predicts on each accepted transaction
  always @(posedge clk_i) begin
    logic valid_nx;
    if (rst_ni) begin
      valid_nx = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        decode_byte(data_byte_i, file_start_i);
        valid_nx = 1'b0;
        if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
        tx_gap = (rx_hold != 0) ? 0 : draw_gap(tx_burst);
      end
      if (!valid_nx) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (bytes_to_send.size() != 0 &&
                     !(bytes_to_send[0].drain && results_due.size() != 0)) begin
          data_byte_i  <= bytes_to_send[0].data;
          file_start_i <= bytes_to_send[0].start;
          bytes_to_send.pop_front();
          valid_nx = 1'b1;
        end
      end
      in_valid_i <= valid_nx;
    end
  end

  // Monitor: checks each accepted result and drives the stall
  always @(posedge clk_i) begin
    decoded_t got;
    decoded_t want;
    logic     stall_nx;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got = '{kind_o, color_o, last_pixel_o, image_width_o, image_height_o};
        if (results_due.size() == 0) begin
          $error("unexpected result: kind %0d color %08h", got.kind, got.color);
          err_cnt++;
        end else begin
          want = results_due.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, got.kind);
            err_cnt++;
          end
          if (got.color !== want.color) begin
            $error("color: expected %08h, got %08h", want.color, got.color);
            err_cnt++;
          end
          if (got.last !== want.last) begin
            $error("last_pixel: expected %0d, got %0d", want.last, got.last);
            err_cnt++;
          end
          if (got.width !== want.width) begin
            $error("image_width: expected %0d, got %0d", want.width, got.width);
            err_cnt++;
          end
          if (got.height !== want.height) begin
            $error("image_height: expected %0d, got %0d", want.height, got.height);
            err_cnt++;
          end
        end
        rx_count++;
        // long hold-off so the core backs up into its input
        if (rx_count == 10 || rx_count == 40) rx_hold = HOLD_CYCLES;
        if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
        rx_gap = draw_gap(rx_burst);
      end
      if (rx_hold != 0) begin
        rx_hold--;
        stall_nx = 1'b1;
      end else if (rx_gap != 0) begin
        rx_gap--;
        stall_nx = 1'b1;
      end else begin
        stall_nx = 1'b0;
      end
      out_stall_i <= stall_nx;
    end
  end

  // Timeout
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb_top: errors");
    $finish;
  end

  // Stimulus and end of run
  initial begin
    int unsigned file_no;
    int          cut;
    int          tail;
    logic [7:0]  wb;
    logic [7:0]  hb;
    logic [7:0]  cb;
    logic [7:0]  ver;

    // bytes before any file start are dropped
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'hA5, 1'b0, 1'b0);
    // unsupported versions, the rest of the file dropped
    add_byte(8'hFF, 1'b1, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);
    add_byte(8'h01, 1'b1, 1'b0);
    // 3x1 image, two entries, one index out of range, one trailing byte
    add_byte(VERSION_0, 1'b1, 1'b0);
    add_byte(8'd3, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'd2, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h80, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(8'h7F, 1'b0, 1'b0);
    add_byte(8'd0, 1'b0, 1'b0);
    add_byte(8'd1, 1'b0, 1'b0);
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h00, 1'b0, 1'b0);

    // random files, mostly well formed and small
    file_no = 0;
    while (queued_cnt < 22 + RAND_BYTES) begin
      file_no++;
      if (file_no == 2) begin
        // full 256-entry palette and a 1x1 image
        add_file(VERSION_0, 8'd1, 8'd1, 8'd0, -1, 0, 1'b0);
      end else if (file_no == 5) begin
        // 256x1 image, cut short after its first pixels
        add_file(VERSION_0, 8'd0, 8'd1, 8'($urandom_range(1, 8)), 60, 0, 1'b0);
      end else begin
        ver = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : VERSION_0;
        if ($urandom_range(0, 15) == 0) begin
          wb = 8'($urandom_range(9, 40));
          hb = 8'd1;
        end else begin
          wb = 8'($urandom_range(1, 6));
          hb = 8'($urandom_range(1, 6));
        end
        cb   = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(9, 40)) :
                                             8'($urandom_range(1, 8));
        cut  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : -1;
        tail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        add_file(ver, wb, hb, cb, cut, tail, file_no == 1 || $urandom_range(0, 19) == 0);
      end
      if ($urandom_range(0, 9) == 0) add_byte(8'($urandom), 1'b0, 1'b0);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_to_send.size() != 0 || in_valid_i) @(posedge clk_i);
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (END_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
